>>> rtl/ezlr_pkg.sv
// ----------------------------------------------------------------------------
// ezlr_pkg
// shared types and constants of the eight zone line rasterizer
// ----------------------------------------------------------------------------
package ezlr_pkg;

  localparam int unsigned COORD_BITS_DEF = 11;

  // item kinds carried on the input tuser bit
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_STEP = 1'b1;

  // octant of the line vector, counter-clockwise from east-north-east
  typedef enum logic [2:0] {
    OCT_ENE = 3'd0,
    OCT_NNE = 3'd1,
    OCT_NNW = 3'd2,
    OCT_WNW = 3'd3,
    OCT_WSW = 3'd4,
    OCT_SSW = 3'd5,
    OCT_SSE = 3'd6,
    OCT_ESE = 3'd7
  } oct_e;

endpackage

>>> rtl/ezlr_setup.sv
// ----------------------------------------------------------------------------
// ezlr_setup
// line setup: octant, mirror into octant zero, decision term and increments
// ----------------------------------------------------------------------------
module ezlr_setup #(
  parameter int unsigned COORD_BITS = ezlr_pkg::COORD_BITS_DEF
) (
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  output ezlr_pkg::oct_e               octant_o,
  output logic signed [COORD_BITS:0]   walk_x_o,
  output logic signed [COORD_BITS:0]   walk_y_o,
  output logic signed [COORD_BITS:0]   stop_x_o,
  output logic signed [COORD_BITS+3:0] decision_o,
  output logic signed [COORD_BITS+2:0] step_e_o,
  output logic signed [COORD_BITS+2:0] step_ne_o
);

  localparam int unsigned W  = COORD_BITS + 1;
  localparam int unsigned DW = COORD_BITS + 4;
  localparam int unsigned SW = COORD_BITS + 3;

  logic signed [W-1:0]  sx, sy, ex, ey;
  logic signed [W-1:0]  dx, dy, adx, ady;
  logic signed [W-1:0]  major, minor;
  logic                 steep;
  ezlr_pkg::oct_e       oct;
  logic signed [DW-1:0] major_w, minor_w;
  logic signed [SW-1:0] major_s, minor_s;

  // octant-zero x of a point
  function automatic logic signed [W-1:0] zero_a(ezlr_pkg::oct_e o,
                                                 logic signed [W-1:0] x,
                                                 logic signed [W-1:0] y);
    logic signed [W-1:0] r;
    unique case (o)
      ezlr_pkg::OCT_ENE: r = x;
      ezlr_pkg::OCT_NNE: r = y;
      ezlr_pkg::OCT_NNW: r = y;
      ezlr_pkg::OCT_WNW: r = -x;
      ezlr_pkg::OCT_WSW: r = -x;
      ezlr_pkg::OCT_SSW: r = -y;
      ezlr_pkg::OCT_SSE: r = -y;
      default:           r = x;
    endcase
    return r;
  endfunction

  // octant-zero y of a point
  function automatic logic signed [W-1:0] zero_b(ezlr_pkg::oct_e o,
                                                 logic signed [W-1:0] x,
                                                 logic signed [W-1:0] y);
    logic signed [W-1:0] r;
    unique case (o)
      ezlr_pkg::OCT_ENE: r = y;
      ezlr_pkg::OCT_NNE: r = x;
      ezlr_pkg::OCT_NNW: r = -x;
      ezlr_pkg::OCT_WNW: r = y;
      ezlr_pkg::OCT_WSW: r = -y;
      ezlr_pkg::OCT_SSW: r = -x;
      ezlr_pkg::OCT_SSE: r = x;
      default:           r = -y;
    endcase
    return r;
  endfunction

  assign sx = {start_x_i[COORD_BITS-1], start_x_i};
  assign sy = {start_y_i[COORD_BITS-1], start_y_i};
  assign ex = {end_x_i[COORD_BITS-1], end_x_i};
  assign ey = {end_y_i[COORD_BITS-1], end_y_i};

  assign dx  = ex - sx;
  assign dy  = ey - sy;
  assign adx = dx[W-1] ? -dx : dx;
  assign ady = dy[W-1] ? -dy : dy;

  // ties go to the flat octant
  assign steep = ady > adx;

  always_comb begin
    unique case ({dx[W-1], dy[W-1]})
      2'b00:   oct = steep ? ezlr_pkg::OCT_NNE : ezlr_pkg::OCT_ENE;
      2'b10:   oct = steep ? ezlr_pkg::OCT_NNW : ezlr_pkg::OCT_WNW;
      2'b11:   oct = steep ? ezlr_pkg::OCT_SSW : ezlr_pkg::OCT_WSW;
      default: oct = steep ? ezlr_pkg::OCT_SSE : ezlr_pkg::OCT_ESE;
    endcase
  end

  // octant-zero deltas are the long and short axis lengths
  assign major = steep ? ady : adx;
  assign minor = steep ? adx : ady;

  assign major_w = DW'(major);
  assign minor_w = DW'(minor);
  assign major_s = SW'(major);
  assign minor_s = SW'(minor);

  assign octant_o   = oct;
  assign walk_x_o   = zero_a(oct, sx, sy);
  assign walk_y_o   = zero_b(oct, sx, sy);
  assign stop_x_o   = zero_a(oct, ex, ey);
  assign decision_o = (minor_w <<< 1) - major_w;
  assign step_e_o   = minor_s <<< 1;
  assign step_ne_o  = (minor_s - major_s) <<< 1;

endmodule

>>> rtl/ezlr_core.sv
// ----------------------------------------------------------------------------
// ezlr_core
// line walk state, one midpoint step per item and mapping back to the octant
// ----------------------------------------------------------------------------
module ezlr_core #(
  parameter int unsigned COORD_BITS = ezlr_pkg::COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  logic                         mode_i,
  input  ezlr_pkg::oct_e               octant_i,
  input  logic signed [COORD_BITS:0]   walk_x_i,
  input  logic signed [COORD_BITS:0]   walk_y_i,
  input  logic signed [COORD_BITS:0]   stop_x_i,
  input  logic signed [COORD_BITS+3:0] decision_i,
  input  logic signed [COORD_BITS+2:0] step_e_i,
  input  logic signed [COORD_BITS+2:0] step_ne_i,
  output logic signed [COORD_BITS-1:0] pix_x_o,
  output logic signed [COORD_BITS-1:0] pix_y_o,
  output logic                         pix_valid_o,
  output logic                         pix_last_o
);

  localparam int unsigned W  = COORD_BITS + 1;
  localparam int unsigned DW = COORD_BITS + 4;
  localparam int unsigned SW = COORD_BITS + 3;

  logic                 busy_q, busy_d;
  ezlr_pkg::oct_e       oct_q, oct_d;
  logic signed [W-1:0]  walk_x_q, walk_x_d;
  logic signed [W-1:0]  walk_y_q, walk_y_d;
  logic signed [W-1:0]  stop_x_q, stop_x_d;
  logic signed [DW-1:0] dec_q, dec_d;
  logic signed [SW-1:0] step_e_q, step_e_d;
  logic signed [SW-1:0] step_ne_q, step_ne_d;

  logic                 do_step, last;
  logic signed [W-1:0]  na, nb, px, py;

  assign do_step = (mode_i == ezlr_pkg::MODE_STEP) && busy_q;
  assign last    = walk_x_q >= stop_x_q;
  assign na      = -walk_x_q;
  assign nb      = -walk_y_q;

  always_comb begin
    unique case (oct_q)
      ezlr_pkg::OCT_ENE: begin px = walk_x_q; py = walk_y_q; end
      ezlr_pkg::OCT_NNE: begin px = walk_y_q; py = walk_x_q; end
      ezlr_pkg::OCT_NNW: begin px = nb;       py = walk_x_q; end
      ezlr_pkg::OCT_WNW: begin px = na;       py = walk_y_q; end
      ezlr_pkg::OCT_WSW: begin px = na;       py = nb;       end
      ezlr_pkg::OCT_SSW: begin px = nb;       py = na;       end
      ezlr_pkg::OCT_SSE: begin px = walk_y_q; py = na;       end
      default:           begin px = walk_x_q; py = nb;       end
    endcase
  end

  assign pix_x_o     = do_step ? px[COORD_BITS-1:0] : '0;
  assign pix_y_o     = do_step ? py[COORD_BITS-1:0] : '0;
  assign pix_valid_o = do_step;
  assign pix_last_o  = do_step && last;

  always_comb begin
    busy_d    = busy_q;
    oct_d     = oct_q;
    walk_x_d  = walk_x_q;
    walk_y_d  = walk_y_q;
    stop_x_d  = stop_x_q;
    dec_d     = dec_q;
    step_e_d  = step_e_q;
    step_ne_d = step_ne_q;
    if (adv_i) begin
      if (mode_i == ezlr_pkg::MODE_LOAD) begin
        busy_d    = 1'b1;
        oct_d     = octant_i;
        walk_x_d  = walk_x_i;
        walk_y_d  = walk_y_i;
        stop_x_d  = stop_x_i;
        dec_d     = decision_i;
        step_e_d  = step_e_i;
        step_ne_d = step_ne_i;
      end else if (busy_q) begin
        // negative decision moves east, otherwise north-east
        if (dec_q[DW-1]) begin
          dec_d = dec_q + DW'(step_e_q);
        end else begin
          dec_d    = dec_q + DW'(step_ne_q);
          walk_y_d = walk_y_q + W'(1);
        end
        walk_x_d = walk_x_q + W'(1);
        busy_d   = !last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      oct_q     <= ezlr_pkg::OCT_ENE;
      walk_x_q  <= '0;
      walk_y_q  <= '0;
      stop_x_q  <= '0;
      dec_q     <= '0;
      step_e_q  <= '0;
      step_ne_q <= '0;
    end else begin
      busy_q    <= busy_d;
      oct_q     <= oct_d;
      walk_x_q  <= walk_x_d;
      walk_y_q  <= walk_y_d;
      stop_x_q  <= stop_x_d;
      dec_q     <= dec_d;
      step_e_q  <= step_e_d;
      step_ne_q <= step_ne_d;
    end
  end

endmodule

>>> rtl/eight_zone_line_rasterizer.sv
// ----------------------------------------------------------------------------
// eight_zone_line_rasterizer
// midpoint line rasterizer over all eight octants, stream in and stream out
// ----------------------------------------------------------------------------
// Every input item gives exactly one output item. A load item (tuser 0)
// takes two endpoints and gives an output item with tuser 0 and zero data.
// Each step item (tuser 1) gives the next pixel of the line with tuser 1,
// from the start point to the end point inclusive; tlast marks the final
// pixel. A step with no line in progress gives tuser 0 and zero data.
// The block takes one item per clock while the output is not stalled:
// an item passes an input register, the setup or walk logic and a result
// register, and a stalled output holds the item in the input register. The
// rate is set by the decision update of the line walk.
module eight_zone_line_rasterizer #(
  parameter int unsigned COORD_BITS = ezlr_pkg::COORD_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // start_x, start_y, end_x, end_y, zero pad
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
  // mode
  input  logic                                   s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // pix_x, pix_y, zero pad
  output logic [((2*COORD_BITS+7)/8)*8-1:0]      m_axis_tdata,
  // pix_valid
  output logic                                   m_axis_tuser,
  output logic                                   m_axis_tlast
);

  localparam int unsigned N     = COORD_BITS;
  localparam int unsigned OUT_W = ((2*COORD_BITS+7)/8)*8;

  logic                 in_valid_q, in_valid_d;
  logic                 in_mode_q;
  logic [4*N-1:0]       in_coords_q;
  logic                 out_valid_q, out_valid_d;
  logic signed [N-1:0]  out_x_q, out_y_q;
  logic                 out_pv_q, out_pl_q;

  logic                 s_acc, advance;

  ezlr_pkg::oct_e       su_oct;
  logic signed [N:0]    su_walk_x, su_walk_y, su_stop_x;
  logic signed [N+3:0]  su_dec;
  logic signed [N+2:0]  su_step_e, su_step_ne;

  logic signed [N-1:0]  pix_x, pix_y;
  logic                 pix_valid, pix_last;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_acc) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_mode_q   <= s_axis_tuser;
      in_coords_q <= s_axis_tdata[4*N-1:0];
    end
    if (advance) begin
      out_x_q  <= pix_x;
      out_y_q  <= pix_y;
      out_pv_q <= pix_valid;
      out_pl_q <= pix_last;
    end
  end

  ezlr_setup #(
    .COORD_BITS (COORD_BITS)
  ) u_setup (
    .start_x_i  (in_coords_q[N-1:0]),
    .start_y_i  (in_coords_q[2*N-1:N]),
    .end_x_i    (in_coords_q[3*N-1:2*N]),
    .end_y_i    (in_coords_q[4*N-1:3*N]),
    .octant_o   (su_oct),
    .walk_x_o   (su_walk_x),
    .walk_y_o   (su_walk_y),
    .stop_x_o   (su_stop_x),
    .decision_o (su_dec),
    .step_e_o   (su_step_e),
    .step_ne_o  (su_step_ne)
  );

  ezlr_core #(
    .COORD_BITS (COORD_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (advance),
    .mode_i      (in_mode_q),
    .octant_i    (su_oct),
    .walk_x_i    (su_walk_x),
    .walk_y_i    (su_walk_y),
    .stop_x_i    (su_stop_x),
    .decision_i  (su_dec),
    .step_e_i    (su_step_e),
    .step_ne_i   (su_step_ne),
    .pix_x_o     (pix_x),
    .pix_y_o     (pix_y),
    .pix_valid_o (pix_valid),
    .pix_last_o  (pix_last)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'({out_y_q, out_x_q});
  assign m_axis_tuser  = out_pv_q;
  assign m_axis_tlast  = out_pl_q;

`ifndef ASSERT_OFF
  a_no_pix_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata == '0) && !m_axis_tlast)
    else $error("non-pixel item carries data");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q)
    else $error("input register lost an item");

  a_load_no_pix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (in_mode_q == ezlr_pkg::MODE_LOAD) |=> out_valid_q && !out_pv_q)
    else $error("load item produced a pixel");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input stalled with empty result register");
`endif

endmodule
